[rtl/core/sld_pkg.sv]
package sld_pkg;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  table_index;
    logic [23:0] table_word;
    logic [11:0] solar_year;
    logic [3:0]  solar_month;
    logic [4:0]  solar_day;
  } sld_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic        is_leap_month;
  } sld_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_RDP,
    S_PREV,
    S_FWD,
    S_BWD,
    S_OUT
  } sld_state_t;

  typedef struct packed {
    logic neg;
    logic pos;
  } sld_cmp_t;

  localparam logic        CMD_LOAD    = 1'b0;
  localparam logic        CMD_CONVERT = 1'b1;
  localparam logic [11:0] YEAR_BASE   = 12'd1901;
  localparam logic [11:0] YEAR_MIN    = 12'd1902;
  localparam logic [11:0] YEAR_MAX    = 12'd2099;
  localparam logic [4:0]  MAX_STEPS   = 5'd20;
  localparam logic [4:0]  LEN_SHORT   = 5'd29;
  localparam logic [4:0]  LEN_LONG    = 5'd30;
  localparam logic [4:0]  SLOT_LAST   = 5'd20;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;

  // days before the first of month m (non-leap year)
  function automatic logic [8:0] sld_month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // length of month slot k (1-based); slot 1 is bit 19
  function automatic logic [4:0] sld_month_len(input logic [23:0] w, input logic [4:0] k);
    logic [4:0] pos;
    logic       long_m;
    pos    = SLOT_LAST - k;
    long_m = (k >= 5'd1) && (k <= SLOT_LAST) && w[pos];
    return long_m ? LEN_LONG : LEN_SHORT;
  endfunction

  // day of year (0-based) of the lunar new year
  function automatic logic signed [9:0] sld_new_year(input logic [23:0] w);
    logic signed [9:0] base;
    base = $signed({5'b0, w[4:0]}) - 10'sd1;
    return base + ((w[6:5] == 2'b01) ? 10'sd0 : 10'sd31);
  endfunction

endpackage

[rtl/core/sld_step_alu.sv]
module sld_step_alu (
  input  logic signed [9:0] op_a,
  input  logic signed [9:0] op_b,
  output logic signed [9:0] diff,
  output sld_pkg::sld_cmp_t flags
);
  import sld_pkg::*;

  always_comb begin
    diff      = op_a - op_b;
    flags.neg = diff[9];
    flags.pos = !diff[9] && (diff != 10'sd0);
  end

endmodule

[rtl/core/solar_to_lunar_date.sv]
// solar_to_lunar_date: Gregorian date to lunar year, month, day and leap flag.
// Input channel (in_valid/in_ready/in_data) carries two kinds of item.
//   cmd = load:    writes table_word into year-info entry table_index
//                  (entry n is lunar year 1901+n); no result.
//   cmd = convert: one result item on out_valid/out_ready/out_data.
// in_ready is high only while the sequencer is idle; one item at a time.
// Convert sequence: an out-of-range date goes straight to the output state;
// a date on/after lunar new year walks months forward through its entry;
// a date before it takes a second table read (previous lunar year) and
// walks months back; both walks stop at MAX_STEPS months.
// The cost is set by the month walk: one subtract/compare unit handles one
// month per cycle. A finished result sits in the output register; while it
// is not taken, loads are still accepted, but the next convert parks in its
// final state and holds off input. Reset clears the sequencer and the output valid; the
// year-info table is not cleared and must be loaded before use.
module solar_to_lunar_date #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sld_pkg::sld_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sld_pkg::sld_out_t out_data
);
  import sld_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [23:0] mem [TABLE_DEPTH];
  logic [23:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  sld_state_t state_r, state_nxt;
  logic        ok_r, ok_nxt;
  logic [11:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  d_r, d_nxt;
  logic signed [9:0] sdays_r, sdays_nxt;
  logic signed [9:0] acc_r, acc_nxt;
  logic [23:0] word_r, word_nxt;
  logic [11:0] lyear_r, lyear_nxt;
  logic [3:0]  lmonth_r, lmonth_nxt;
  logic [4:0]  lday_r, lday_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [4:0]  steps_r, steps_nxt;
  logic        flag_r, flag_nxt;
  logic        out_valid_r, out_valid_nxt;
  sld_out_t    out_r, out_nxt;

  logic              in_acc;
  logic              out_load;
  logic              date_ok;
  logic              step_ok;
  logic [3:0]        leapm;
  logic [3:0]        lm_dec;
  logic [4:0]        mdays;
  logic signed [9:0] nyear;
  logic signed [9:0] alu_a, alu_b, alu_diff;
  sld_cmp_t          alu_flags;

  sld_step_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .diff  (alu_diff),
    .flags (alu_flags)
  );

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign date_ok  = (in_data.solar_year >= YEAR_MIN) && (in_data.solar_year <= YEAR_MAX) &&
                    (in_data.solar_month >= 4'd1) && (in_data.solar_month <= MONTH_LAST) &&
                    (in_data.solar_day >= 5'd1);
  assign rd_addr  = (state_r == S_RDP) ? AW'(y_r - YEAR_MIN) : AW'(y_r - YEAR_BASE);
  assign leapm    = word_r[23:20];
  assign mdays    = sld_month_len(word_r, idx_r);
  assign nyear    = sld_new_year(rd_data_r);
  assign step_ok  = steps_r < MAX_STEPS;
  assign lm_dec   = flag_r ? lmonth_r : lmonth_r - 4'd1;

  always_comb begin
    if (state_r == S_CMP) begin
      alu_a = sdays_r;
      alu_b = nyear;
    end else begin
      alu_a = acc_r;
      alu_b = $signed({5'b0, mdays});
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.cmd == CMD_CONVERT) begin
          state_nxt = date_ok ? S_RD : S_OUT;
        end
      end
      S_RD:   state_nxt = S_CMP;
      S_CMP:  state_nxt = alu_flags.neg ? S_RDP : S_FWD;
      S_RDP:  state_nxt = S_PREV;
      S_PREV: state_nxt = S_BWD;
      S_FWD: begin
        if (alu_flags.neg || !step_ok) begin
          state_nxt = S_OUT;
        end
      end
      S_BWD: begin
        if (!alu_flags.pos || !step_ok) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ok_nxt     = ok_r;
    y_nxt      = y_r;
    m_nxt      = m_r;
    d_nxt      = d_r;
    sdays_nxt  = sdays_r;
    acc_nxt    = acc_r;
    word_nxt   = word_r;
    lyear_nxt  = lyear_r;
    lmonth_nxt = lmonth_r;
    lday_nxt   = lday_r;
    idx_nxt    = idx_r;
    steps_nxt  = steps_r;
    flag_nxt   = flag_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.cmd == CMD_CONVERT) begin
          ok_nxt    = date_ok;
          y_nxt     = in_data.solar_year;
          m_nxt     = in_data.solar_month;
          d_nxt     = in_data.solar_day;
          lyear_nxt = in_data.solar_year;
        end
      end
      S_RD: begin
        sdays_nxt = $signed({1'b0, sld_month_offset(m_r)}) + $signed({5'b0, d_r}) - 10'sd1;
        if (y_r[1:0] == 2'b00 && m_r > 4'd2) begin
          sdays_nxt = $signed({1'b0, sld_month_offset(m_r)}) + $signed({5'b0, d_r});
        end
      end
      S_CMP: begin
        word_nxt = rd_data_r;
        if (alu_flags.neg) begin
          acc_nxt   = 10'sd0 - alu_diff;
          lyear_nxt = y_r - 12'd1;
        end else begin
          acc_nxt    = alu_diff;
          lmonth_nxt = 4'd1;
          idx_nxt    = 5'd1;
          steps_nxt  = 5'd0;
          flag_nxt   = 1'b0;
        end
      end
      S_RDP: begin
      end
      S_PREV: begin
        word_nxt   = rd_data_r;
        idx_nxt    = (rd_data_r[23:20] == 4'd0) ? 5'd12 : 5'd13;
        lmonth_nxt = MONTH_LAST;
        steps_nxt  = 5'd0;
        flag_nxt   = 1'b0;
      end
      S_FWD: begin
        if (!alu_flags.neg && step_ok) begin
          acc_nxt   = alu_diff;
          idx_nxt   = idx_r + 5'd1;
          steps_nxt = steps_r + 5'd1;
          if (lmonth_r == leapm) begin
            flag_nxt = !flag_r;
            if (flag_r) begin
              lmonth_nxt = lmonth_r + 4'd1;
            end
          end else begin
            lmonth_nxt = lmonth_r + 4'd1;
          end
        end else begin
          lday_nxt = 5'(acc_r + 10'sd1);
        end
      end
      S_BWD: begin
        if (alu_flags.pos && step_ok) begin
          acc_nxt    = alu_diff;
          idx_nxt    = idx_r - 5'd1;
          steps_nxt  = steps_r + 5'd1;
          lmonth_nxt = lm_dec;
          if (lm_dec == leapm) begin
            flag_nxt = !flag_r;
          end
        end else begin
          lday_nxt = 5'(10'sd1 - alu_diff);
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    out_valid     = out_valid_r;
    out_data      = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (ok_r) begin
        out_nxt.valid_res     = 1'b1;
        out_nxt.cal_year      = lyear_r;
        out_nxt.cal_month     = lmonth_r;
        out_nxt.cal_day       = lday_r;
        out_nxt.is_leap_month = flag_r && (lmonth_r == leapm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.cmd == CMD_LOAD && 32'(in_data.table_index) < TABLE_DEPTH) begin
      mem[AW'(in_data.table_index)] <= in_data.table_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r     <= ok_nxt;
    y_r      <= y_nxt;
    m_r      <= m_nxt;
    d_r      <= d_nxt;
    sdays_r  <= sdays_nxt;
    acc_r    <= acc_nxt;
    word_r   <= word_nxt;
    lyear_r  <= lyear_nxt;
    lmonth_r <= lmonth_nxt;
    lday_r   <= lday_nxt;
    idx_r    <= idx_nxt;
    steps_r  <= steps_nxt;
    flag_r   <= flag_nxt;
    out_r    <= out_nxt;
  end

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD || state_r == S_BWD) |-> steps_r <= MAX_STEPS)
    else $error("month walk exceeded step bound");

  a_convert_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_CONVERT) |=> (state_r == S_RD || state_r == S_OUT))
    else $error("convert item did not start the sequencer");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.valid_res) |->
      (out_r.cal_month == 4'd0 && out_r.cal_day == 5'd0 && !out_r.is_leap_month))
    else $error("invalid result carries nonzero fields");

  a_back_year: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BWD) |-> (lyear_r == y_r - 12'd1))
    else $error("backward walk without previous lunar year");

endmodule

[test/tb_solar_to_lunar_date.sv]
`timescale 1ns / 1ps

module tb_solar_to_lunar_date;
  import sld_pkg::*;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  class lunar_checker;
    logic [23:0] year_info[DEPTH];
    sld_out_t    lunar_due[$];
    int          errors = 0;
    int          days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function int slot_len(logic [23:0] w, int k);
      if (k < 1 || k > 20) return 29;
      return w[20 - k] ? 30 : 29;
    endfunction

    function sld_out_t lunar_of(sld_in_t it);
      sld_out_t    r;
      logic [23:0] info;
      int          y, m, d, nyear, sdays, lyear, lmonth, lday, idx, mdays, steps, leapm;
      bit          flag;
      r = '0;
      flag = 1'b0;
      y = it.solar_year;
      m = it.solar_month;
      d = it.solar_day;
      if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12 || d < 1) return r;
      info = year_info[y - YEAR_BASE];
      nyear = info[4:0];
      nyear = nyear - 1 + ((info[6:5] == 2'b01) ? 0 : 31);
      sdays = days_before[m - 1] + d - 1;
      if (((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) && m > 2) sdays++;
      lyear = y;
      if (sdays >= nyear) begin
        leapm = info[23:20];
        sdays -= nyear;
        lmonth = 1;
        idx = 1;
        mdays = slot_len(info, idx);
        steps = 0;
        while (sdays >= mdays && steps < 20) begin
          sdays -= mdays;
          idx++;
          steps++;
          if (lmonth == leapm) begin
            flag = !flag;
            if (!flag) lmonth++;
          end else begin
            lmonth++;
          end
          mdays = slot_len(info, idx);
        end
        lday = sdays + 1;
      end else begin
        nyear -= sdays;
        lyear--;
        lmonth = 12;
        info = year_info[lyear - YEAR_BASE];
        leapm = info[23:20];
        idx = (leapm == 0) ? 12 : 13;
        mdays = slot_len(info, idx);
        steps = 0;
        while (nyear > mdays && steps < 20) begin
          nyear -= mdays;
          idx--;
          steps++;
          if (!flag) lmonth--;
          if (lmonth == leapm) flag = !flag;
          mdays = slot_len(info, idx);
        end
        lday = mdays - nyear + 1;
      end
      r.valid_res     = 1'b1;
      r.cal_year      = lyear[11:0];
      r.cal_month     = lmonth[3:0];
      r.cal_day       = lday[4:0];
      r.is_leap_month = flag && (lmonth == leapm);
      return r;
    endfunction

    function void note_item(sld_in_t it);
      if (it.cmd == CMD_LOAD) begin
        if (it.table_index < DEPTH) year_info[it.table_index] = it.table_word;
      end else begin
        lunar_due.push_back(lunar_of(it));
      end
    endfunction

    function int due_count();
      return lunar_due.size();
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_item(sld_out_t got);
      sld_out_t want;
      if (lunar_due.size() == 0) begin
        report("result with nothing due, cal_year", got.cal_year, 0);
        return;
      end
      want = lunar_due.pop_front();
      if (got.valid_res != want.valid_res) report("valid_res", got.valid_res, want.valid_res);
      if (got.cal_year != want.cal_year) report("cal_year", got.cal_year, want.cal_year);
      if (got.cal_month != want.cal_month)
        report("cal_month", got.cal_month, want.cal_month);
      if (got.cal_day != want.cal_day) report("cal_day", got.cal_day, want.cal_day);
      if (got.is_leap_month != want.is_leap_month)
        report("is_leap_month", got.is_leap_month, want.is_leap_month);
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sld_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sld_out_t out_data;

  lunar_checker sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  solar_to_lunar_date #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_item(out_data);
  end

  function automatic logic [23:0] year_word();
    logic [23:0] w;
    w = 24'($urandom);
    if ($urandom_range(7) != 0) begin
      w[23:20] = ($urandom_range(2) == 0) ? 4'($urandom_range(1, 12)) : 4'd0;
      if ($urandom_range(1) == 1) begin
        w[6:5] = 2'b01;
        w[4:0] = 5'($urandom_range(21, 31));
      end else begin
        w[6:5] = 2'b10;
        w[4:0] = 5'($urandom_range(1, 20));
      end
    end
    return w;
  endfunction

  task automatic send_item(input sld_in_t it);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic load(input int idx, input logic [23:0] w);
    sld_in_t it;
    it.cmd         = CMD_LOAD;
    it.table_index = idx[7:0];
    it.table_word  = w;
    it.solar_year  = 12'($urandom);
    it.solar_month = 4'($urandom);
    it.solar_day   = 5'($urandom);
    send_item(it);
  endtask

  task automatic convert(input int y, input int m, input int d);
    sld_in_t it;
    it.cmd         = CMD_CONVERT;
    it.table_index = 8'($urandom);
    it.table_word  = 24'($urandom);
    it.solar_year  = y[11:0];
    it.solar_month = m[3:0];
    it.solar_day   = d[4:0];
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every entry is written before any conversion can read it
    for (int i = 0; i < DEPTH; i++) load(i, year_word());

    // range edges, invalid fields, leap years, days past month end
    convert(1902, 1, 1);
    convert(2099, 12, 31);
    convert(1901, 6, 15);
    convert(2100, 1, 1);
    convert(0, 0, 0);
    convert(4095, 15, 31);
    convert(2000, 0, 10);
    convert(2000, 13, 10);
    convert(2000, 5, 0);
    convert(2001, 2, 31);
    convert(2000, 2, 29);
    convert(2000, 3, 1);
    // new year on Feb 17: the day itself and the day before
    load(48, year_word());
    load(49, {4'd0, 13'h1b5a, 2'b10, 5'd17});
    convert(1950, 2, 17);
    convert(1950, 2, 16);
    // inconsistent words: leap month 15 with all long months, then all zero
    load(99, 24'hffffff);
    convert(2000, 12, 31);
    convert(2001, 1, 1);
    load(99, 24'h000000);
    convert(2000, 1, 31);
    convert(2000, 1, 30);
    load(99, year_word());
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_tag++;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < 180; n++) begin
        r = $urandom_range(99);
        if (r < 15) begin
          load($urandom_range(DEPTH - 1), year_word());
        end else if (r < 27) begin
          convert($urandom_range(4095), $urandom_range(15), $urandom_range(31));
        end else if (r < 60) begin
          convert($urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(1, 2),
                  $urandom_range(1, 31));
        end else begin
          convert($urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(1, 12),
                  $urandom_range(1, 31));
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
